// ----- src/session_lru_cache_macros.svh -----
// Assertion macros used by the checker file slc_checker.sv.
`ifndef SESSION_LRU_CACHE_MACROS_SVH
`define SESSION_LRU_CACHE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SLC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/slc_pkg.sv -----
package slc_pkg;

  localparam int SID_W = 48;
  localparam int SLOT_W = 4;
  localparam int SESSIONS_DEF = 16;

  localparam logic ACT_PRELOAD = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SID_W-1:0]  request_sid;
    logic [SLOT_W-1:0] target_slot;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot_used;
    logic              evicted_valid;
    logic [SID_W-1:0]  evicted_sid;
    logic              error;
  } out_t;

endpackage

// ----- src/session_lru_cache.sv -----
// Each request makes two passes over the entry memory before its result: one
// pass finds the hit, free and least recent slots, and a second
// read-modify-write pass updates the recency ranks, one entry a cycle.
// A new request is taken only in the idle state, after the previous result
// has gone into the output register. A preload to a slot beyond the table
// skips both passes. After reset a clearing pass initializes the memory.
module session_lru_cache #(
  parameter int SESSIONS = slc_pkg::SESSIONS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  slc_pkg::in_t in_item,
  output logic         out_valid,
  input  logic         out_ready,
  output slc_pkg::out_t out_item
);

  localparam int IW = $clog2(SESSIONS);
  localparam int EW = 1 + slc_pkg::SID_W + IW;
  localparam logic [IW-1:0] LAST = IW'(SESSIONS - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_UPDATE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  slc_pkg::in_t cur;
  slc_pkg::out_t res;

  logic [IW-1:0] clr_cnt;
  logic [IW-1:0] rd_cnt;
  logic          issuing;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;

  logic          match_found;
  logic [IW-1:0] match_idx;
  logic [IW-1:0] match_rank;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] free_rank;
  logic [IW-1:0] lru_idx;
  logic [IW-1:0] lru_rank;
  logic [slc_pkg::SID_W-1:0] lru_id;
  logic [IW-1:0] tgt_rank;
  logic          tgt_valid;
  logic [slc_pkg::SID_W-1:0] tgt_id;

  logic [IW-1:0] slot_sel;
  logic [IW-1:0] old_rank;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] mem_rdata;

  logic                      e_valid;
  logic [slc_pkg::SID_W-1:0] e_id;
  logic [IW-1:0]             e_rank;
  logic [IW-1:0]             new_rank;

  slc_mem #(.DEPTH(SESSIONS), .WIDTH(EW)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(rd_cnt),
    .rdata(mem_rdata)
  );

  assign e_valid = mem_rdata[EW-1];
  assign e_id = mem_rdata[IW +: slc_pkg::SID_W];
  assign e_rank = mem_rdata[IW-1:0];
  assign in_ready = (state == S_IDLE);

  // The chosen slot takes rank 0; ranks below its old rank go up by one, the rest stay.
  always_comb begin
    if (rd_idx == slot_sel) begin
      new_rank = '0;
    end else if (e_rank < old_rank) begin
      new_rank = e_rank + IW'(1);
    end else begin
      new_rank = e_rank;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = {1'b0, {slc_pkg::SID_W{1'b0}}, clr_cnt};
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_UPDATE && rd_vld) begin
      mem_we = 1'b1;
      mem_waddr = rd_idx;
      if (rd_idx == slot_sel) begin
        mem_wdata = {1'b1, cur.request_sid, new_rank};
      end else begin
        mem_wdata = {e_valid, e_id, new_rank};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      rd_cnt <= '0;
      issuing <= 1'b0;
      rd_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= issuing;
      rd_idx <= rd_cnt;
      if (issuing) begin
        if (rd_cnt == LAST) begin
          issuing <= 1'b0;
        end else begin
          rd_cnt <= rd_cnt + IW'(1);
        end
      end
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == LAST) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + IW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_item;
            match_found <= 1'b0;
            free_found <= 1'b0;
            if (in_item.action == slc_pkg::ACT_PRELOAD &&
                32'(in_item.target_slot) >= SESSIONS) begin
              res <= '{hit: 1'b0, slot_used: '0, evicted_valid: 1'b0,
                       evicted_sid: '0, error: 1'b1};
              state <= S_FINISH;
            end else begin
              rd_cnt <= '0;
              issuing <= 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (e_valid && e_id == cur.request_sid && !match_found) begin
              match_found <= 1'b1;
              match_idx <= rd_idx;
              match_rank <= e_rank;
            end
            if (!e_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx <= rd_idx;
              free_rank <= e_rank;
            end
            if (e_rank == LAST) begin
              lru_idx <= rd_idx;
              lru_rank <= e_rank;
              lru_id <= e_id;
            end
            if (32'(rd_idx) == 32'(cur.target_slot)) begin
              tgt_rank <= e_rank;
              tgt_valid <= e_valid;
              tgt_id <= e_id;
            end
            if (rd_idx == LAST) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          res.error <= 1'b0;
          if (cur.action == slc_pkg::ACT_PRELOAD) begin
            slot_sel <= IW'(cur.target_slot);
            old_rank <= tgt_rank;
            res.hit <= 1'b0;
            res.slot_used <= cur.target_slot;
            res.evicted_valid <= tgt_valid;
            res.evicted_sid <= tgt_valid ? tgt_id : '0;
          end else if (match_found) begin
            slot_sel <= match_idx;
            old_rank <= match_rank;
            res.hit <= 1'b1;
            res.slot_used <= slc_pkg::SLOT_W'(match_idx);
            res.evicted_valid <= 1'b0;
            res.evicted_sid <= '0;
          end else if (free_found) begin
            slot_sel <= free_idx;
            old_rank <= free_rank;
            res.hit <= 1'b0;
            res.slot_used <= slc_pkg::SLOT_W'(free_idx);
            res.evicted_valid <= 1'b0;
            res.evicted_sid <= '0;
          end else begin
            slot_sel <= lru_idx;
            old_rank <= lru_rank;
            res.hit <= 1'b0;
            res.slot_used <= slc_pkg::SLOT_W'(lru_idx);
            res.evicted_valid <= 1'b1;
            res.evicted_sid <= lru_id;
          end
          rd_cnt <= '0;
          issuing <= 1'b1;
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (rd_vld && rd_idx == LAST) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_item <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// ----- src/slc_mem.sv -----
module slc_mem #(
  parameter int DEPTH = slc_pkg::SESSIONS_DEF,
  parameter int WIDTH = 1 + slc_pkg::SID_W + $clog2(slc_pkg::SESSIONS_DEF)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/slc_checker.sv -----
`include "session_lru_cache_macros.svh"

module slc_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input slc_pkg::out_t out_item
);

  logic out_wait;
  logic err_clean;
  logic hit_clean;

  assign out_wait = out_valid && !out_ready;
  assign err_clean = !out_item.hit && !out_item.evicted_valid &&
                     out_item.evicted_sid == '0 && out_item.slot_used == '0;
  assign hit_clean = !out_item.evicted_valid && out_item.evicted_sid == '0 &&
                     !out_item.error;

  `SLC_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, out_valid)
  `SLC_ASSERT_NEXT(a_out_stable, clk, rst, out_wait, $stable(out_item))
  `SLC_ASSERT_NOW(a_error_clean, clk, rst, out_valid && out_item.error, err_clean)
  `SLC_ASSERT_NOW(a_hit_no_evict, clk, rst, out_valid && out_item.hit, hit_clean)

endmodule

bind session_lru_cache slc_checker u_slc_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

// ----- sim/session_checker.sv -----
module session_checker #(
  parameter int SESSIONS = slc_pkg::SESSIONS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  slc_pkg::in_t  in_item,
  input  logic          out_valid,
  input  logic          out_ready,
  input  slc_pkg::out_t out_item,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [slc_pkg::SID_W-1:0] sid_tab [SESSIONS];
  logic                      valid_tab [SESSIONS];
  int                        rank_tab [SESSIONS];
  slc_pkg::out_t             expected_q [$];

  assign pending = expected_q.size();

  function automatic void promote(int slot);
    int old;
    old = rank_tab[slot];
    for (int i = 0; i < SESSIONS; i++)
      if (rank_tab[i] < old) rank_tab[i]++;
    rank_tab[slot] = 0;
  endfunction

  function automatic slc_pkg::out_t lookup_or_store(slc_pkg::in_t req);
    slc_pkg::out_t r;
    int victim;
    int worst;
    bit found;
    r = '0;
    if (req.action == slc_pkg::ACT_PRELOAD) begin
      if (int'(req.target_slot) >= SESSIONS) begin
        r.error = 1'b1;
        return r;
      end
      victim = int'(req.target_slot);
    end else begin
      for (int i = 0; i < SESSIONS; i++) begin
        if (valid_tab[i] && sid_tab[i] == req.request_sid) begin
          promote(i);
          r.hit = 1'b1;
          r.slot_used = i[slc_pkg::SLOT_W-1:0];
          return r;
        end
      end
      found = 0;
      victim = 0;
      for (int i = 0; i < SESSIONS; i++) begin
        if (!found && !valid_tab[i]) begin
          victim = i;
          found = 1;
        end
      end
      if (!found) begin
        worst = 0;
        for (int i = 0; i < SESSIONS; i++) begin
          if (rank_tab[i] >= worst) begin
            worst = rank_tab[i];
            victim = i;
          end
        end
      end
    end
    r.slot_used = victim[slc_pkg::SLOT_W-1:0];
    r.evicted_valid = valid_tab[victim];
    r.evicted_sid = valid_tab[victim] ? sid_tab[victim] : '0;
    sid_tab[victim] = req.request_sid;
    valid_tab[victim] = 1'b1;
    promote(victim);
    return r;
  endfunction

  always @(posedge clk) begin
    slc_pkg::out_t want;
    if (rst) begin
      for (int i = 0; i < SESSIONS; i++) begin
        sid_tab[i] = '0;
        valid_tab[i] = 1'b0;
        rank_tab[i] = i;
      end
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_item.hit !== want.hit) begin
            $error("hit: expected %0h actual %0h", want.hit, out_item.hit);
            fail_count++;
          end
          if (out_item.slot_used !== want.slot_used) begin
            $error("slot_used: expected %0h actual %0h",
                   want.slot_used, out_item.slot_used);
            fail_count++;
          end
          if (out_item.evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0h actual %0h",
                   want.evicted_valid, out_item.evicted_valid);
            fail_count++;
          end
          if (out_item.evicted_sid !== want.evicted_sid) begin
            $error("evicted_sid: expected %0h actual %0h",
                   want.evicted_sid, out_item.evicted_sid);
            fail_count++;
          end
          if (out_item.error !== want.error) begin
            $error("error: expected %0h actual %0h", want.error, out_item.error);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_q.push_back(lookup_or_store(in_item));
    end
  end
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SESSIONS = slc_pkg::SESSIONS_DEF;
  localparam int RANDOM_REQS = 650;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  slc_pkg::in_t  in_item;
  logic          out_valid;
  logic          out_ready;
  slc_pkg::out_t out_item;
  int            fail_count;
  int            pending;
  bit            quiet;
  bit            hold_long;
  logic [slc_pkg::SID_W-1:0] sid_pool [8];

  session_lru_cache #(.SESSIONS(SESSIONS)) u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  session_checker #(.SESSIONS(SESSIONS)) u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [slc_pkg::SID_W-1:0] random_sid();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[slc_pkg::SID_W-1:0];
  endfunction

  // Valid stays up between back-to-back requests and drops only for a gap.
  task automatic send_request(logic act, logic [slc_pkg::SID_W-1:0] sid,
                              logic [slc_pkg::SLOT_W-1:0] slot);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{action: act, request_sid: sid, target_slot: slot};
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stalls, plus one long hold so the block backs up.
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int pick;
    int waited;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    quiet = 0;
    hold_long = 0;
    for (int i = 0; i < 8; i++) sid_pool[i] = random_sid();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill from an empty table, hits, extremes, duplicates, eviction.
    send_request(slc_pkg::ACT_LOOKUP, '0, 4'hF);
    send_request(slc_pkg::ACT_LOOKUP, '1, 4'h0);
    send_request(slc_pkg::ACT_LOOKUP, '0, 4'h5);
    send_request(slc_pkg::ACT_PRELOAD, 48'h5555_AAAA_5555, 4'h0);
    send_request(slc_pkg::ACT_PRELOAD, 48'hAAAA_5555_AAAA, 4'hF);
    send_request(slc_pkg::ACT_PRELOAD, '1, 4'h0);
    send_request(slc_pkg::ACT_PRELOAD, '1, 4'h7);
    send_request(slc_pkg::ACT_LOOKUP, '1, 4'h3);
    for (int i = 0; i < 12; i++)
      send_request(slc_pkg::ACT_LOOKUP, 48'h100 + 48'(i), 4'(i));
    send_request(slc_pkg::ACT_LOOKUP, 48'h100, 4'h0);
    send_request(slc_pkg::ACT_LOOKUP, 48'hDEAD_BEEF_0001, 4'h0);
    send_request(slc_pkg::ACT_LOOKUP, 48'hDEAD_BEEF_0002, 4'h9);

    hold_long = 1;
    for (int i = 0; i < 6; i++) send_request(slc_pkg::ACT_LOOKUP, random_sid(), 4'(i));

    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k > RANDOM_REQS - 80) quiet = 1;
      if (k % 100 == 50) for (int i = 0; i < 8; i++) sid_pool[i] = random_sid();
      pick = $urandom_range(0, 9);
      if (pick < 2)
        send_request(slc_pkg::ACT_PRELOAD,
                     $urandom_range(0, 1) ? sid_pool[$urandom_range(0, 7)] : random_sid(),
                     4'($urandom_range(0, 15)));
      else if (pick < 7)
        send_request(slc_pkg::ACT_LOOKUP, sid_pool[$urandom_range(0, 7)],
                     4'($urandom_range(0, 15)));
      else
        send_request(slc_pkg::ACT_LOOKUP, random_sid(), 4'($urandom_range(0, 15)));
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * SESSIONS + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/slc_pkg.sv
src/slc_mem.sv
src/session_lru_cache.sv
src/slc_checker.sv
sim/session_checker.sv
sim/tb_top.sv
